[hdl/ping_pong_frame_buffer_control_defines.svh]
// ----------------------------------------------------------------------------
// Ping-pong frame buffer control: assertion macros
// Shared concurrent assertion shorthands, clocked on clk with reset rst_n.
// ----------------------------------------------------------------------------
`ifndef PING_PONG_FRAME_BUFFER_CONTROL_DEFINES_SVH
`define PING_PONG_FRAME_BUFFER_CONTROL_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPFB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PPFB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/ppfb_pkg.sv]
// ----------------------------------------------------------------------------
// Ping-pong frame buffer control package
// Event and status codes and the request and response record types.
// ----------------------------------------------------------------------------
package ppfb_pkg;

    // Event codes carried in the cmd field.
    localparam logic [2:0] CMD_START     = 3'd0;
    localparam logic [2:0] CMD_TICK      = 3'd1;
    localparam logic [2:0] CMD_CLAIM     = 3'd2;
    localparam logic [2:0] CMD_BUILD_END = 3'd3;
    localparam logic [2:0] CMD_XFER_DONE = 3'd4;
    localparam logic [2:0] CMD_XFER_ERR  = 3'd5;

    // Timer start outcomes carried in start_result.
    localparam logic [1:0] START_OK       = 2'd0;
    localparam logic [1:0] START_REJECTED = 2'd1;

    // Status codes of a response.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BUSY    = 2'd1;
    localparam logic [1:0] ST_ERROR   = 2'd2;
    localparam logic [1:0] ST_IGNORED = 2'd3;

    // One event request.
    typedef struct packed {
        logic [2:0] cmd;
        logic [1:0] start_result;
        logic       build_ok;
        logic       send_ok;
    } req_t;

    // One response.
    typedef struct packed {
        logic [1:0] status;
        logic       active_buffer;
        logic       build_buffer;
        logic       send_started;
        logic       not_ready;
        logic       busy_flag;
        logic       ready_pending;
        logic       build_requested;
        logic       building;
        logic       running;
    } rsp_t;

endpackage

[hdl/ppfb_evt_if.sv]
// ----------------------------------------------------------------------------
// Ping-pong frame buffer control: event channel
// Valid/ready channel that carries one event request per transfer.
// ----------------------------------------------------------------------------
interface ppfb_evt_if;
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    logic [1:0] start_result;
    logic       build_ok;
    logic       send_ok;

    modport source (output valid, output cmd, output start_result, output build_ok,
                    output send_ok, input ready);
    modport sink (input valid, input cmd, input start_result, input build_ok,
                  input send_ok, output ready);
endinterface

[hdl/ppfb_res_if.sv]
// ----------------------------------------------------------------------------
// Ping-pong frame buffer control: response channel
// Valid/ready channel that carries one response per event.
// ----------------------------------------------------------------------------
interface ppfb_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       active_buffer;
    logic       build_buffer;
    logic       send_started;
    logic       not_ready;
    logic       busy_flag;
    logic       ready_pending;
    logic       build_requested;
    logic       building;
    logic       running;

    modport source (output valid, output status, output active_buffer,
                    output build_buffer, output send_started, output not_ready,
                    output busy_flag, output ready_pending, output build_requested,
                    output building, output running, input ready);
    modport sink (input valid, input status, input active_buffer,
                  input build_buffer, input send_started, input not_ready,
                  input busy_flag, input ready_pending, input build_requested,
                  input building, input running, output ready);
endinterface

[hdl/ppfb_state_core.sv]
// ----------------------------------------------------------------------------
// Ping-pong frame buffer control: state core
// Holds the buffer indices and flags and works out one event's response.
// ----------------------------------------------------------------------------
`include "ping_pong_frame_buffer_control_defines.svh"

module ppfb_state_core
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  ppfb_pkg::req_t req,
    output ppfb_pkg::rsp_t rsp
);

    logic active_reg,   active_next;
    logic build_reg,    build_next;
    logic ready_idx_reg, ready_idx_next;
    logic request_reg,  request_next;
    logic building_reg, building_next;
    logic ready_reg,    ready_next;
    logic running_reg,  running_next;
    logic inflight_reg, inflight_next;
    logic [1:0] status;
    logic started;
    logic missed;

    // Next state and status for the event at the core's input.
    always_comb
    begin
        active_next    = active_reg;
        build_next     = build_reg;
        ready_idx_next = ready_idx_reg;
        request_next   = request_reg;
        building_next  = building_reg;
        ready_next     = ready_reg;
        running_next   = running_reg;
        inflight_next  = inflight_reg;
        status         = ppfb_pkg::ST_IGNORED;
        started        = 1'b0;
        missed         = 1'b0;
        case (req.cmd)
            ppfb_pkg::CMD_START:
            begin
                if (req.start_result == ppfb_pkg::START_REJECTED)
                begin
                    status = ppfb_pkg::ST_ERROR;
                end
                else if (running_reg)
                begin
                    status = ppfb_pkg::ST_BUSY;
                end
                else
                begin
                    active_next    = 1'b0;
                    build_next     = 1'b0;
                    ready_idx_next = 1'b1;
                    request_next   = 1'b0;
                    building_next  = 1'b0;
                    ready_next     = 1'b1;
                    inflight_next  = 1'b0;
                    if (req.start_result == ppfb_pkg::START_OK)
                    begin
                        running_next = 1'b1;
                        status       = ppfb_pkg::ST_OK;
                    end
                    else
                    begin
                        running_next = 1'b0;
                        status       = ppfb_pkg::ST_ERROR;
                    end
                end
            end
            ppfb_pkg::CMD_TICK:
            begin
                if (!running_reg)
                begin
                    status = ppfb_pkg::ST_IGNORED;
                end
                else if (inflight_reg)
                begin
                    status = ppfb_pkg::ST_BUSY;
                end
                else
                begin
                    // Swap in the finished buffer, or repeat the current one.
                    if (ready_reg)
                    begin
                        active_next = ready_idx_reg;
                        ready_next  = 1'b0;
                    end
                    else
                    begin
                        missed = 1'b1;
                    end
                    // Ask for the other buffer unless a build is already requested or open.
                    if (!request_reg && !building_reg)
                    begin
                        build_next   = ~active_next;
                        request_next = 1'b1;
                    end
                    if (req.send_ok)
                    begin
                        inflight_next = 1'b1;
                        started       = 1'b1;
                        status        = ppfb_pkg::ST_OK;
                    end
                    else
                    begin
                        status = ppfb_pkg::ST_ERROR;
                    end
                end
            end
            ppfb_pkg::CMD_CLAIM:
            begin
                if (running_reg && request_reg && !building_reg)
                begin
                    request_next  = 1'b0;
                    building_next = 1'b1;
                    status        = ppfb_pkg::ST_OK;
                end
            end
            ppfb_pkg::CMD_BUILD_END:
            begin
                if (building_reg)
                begin
                    building_next = 1'b0;
                    if (req.build_ok)
                    begin
                        ready_idx_next = build_reg;
                        ready_next     = 1'b1;
                        status         = ppfb_pkg::ST_OK;
                    end
                    else
                    begin
                        request_next = 1'b1;
                        status       = ppfb_pkg::ST_ERROR;
                    end
                end
            end
            ppfb_pkg::CMD_XFER_DONE, ppfb_pkg::CMD_XFER_ERR:
            begin
                if (inflight_reg)
                begin
                    inflight_next = 1'b0;
                    status = (req.cmd == ppfb_pkg::CMD_XFER_DONE) ? ppfb_pkg::ST_OK
                                                                   : ppfb_pkg::ST_ERROR;
                end
            end
            default:
            begin
                status = ppfb_pkg::ST_IGNORED;
            end
        endcase
    end

    // Response reflects the state after the event.
    always_comb
    begin
        rsp.status          = status;
        rsp.active_buffer   = active_next;
        rsp.build_buffer    = build_next;
        rsp.send_started    = started;
        rsp.not_ready       = missed;
        rsp.busy_flag       = inflight_next;
        rsp.ready_pending   = ready_next;
        rsp.build_requested = request_next;
        rsp.building        = building_next;
        rsp.running         = running_next;
    end

    // State update, once per event taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            build_reg     <= 1'b0;
            ready_idx_reg <= 1'b1;
            request_reg   <= 1'b0;
            building_reg  <= 1'b0;
            ready_reg     <= 1'b0;
            running_reg   <= 1'b0;
            inflight_reg  <= 1'b0;
        end
        else if (step)
        begin
            active_reg    <= active_next;
            build_reg     <= build_next;
            ready_idx_reg <= ready_idx_next;
            request_reg   <= request_next;
            building_reg  <= building_next;
            ready_reg     <= ready_next;
            running_reg   <= running_next;
            inflight_reg  <= inflight_next;
        end
    end

    // A build request and a build in progress never coexist.
    `PPFB_ASSERT_NOW(a_req_bld_excl, 1'b1, !(request_reg && building_reg),
        "build requested and building at once")
    // Open requests, builds and transfers exist only while running.
    `PPFB_ASSERT_NOW(a_flags_need_run, request_reg || building_reg || inflight_reg,
        running_reg, "activity flag set while not running")
    // A successful claim leaves the producer building.
    `PPFB_ASSERT_NEXT(a_claim_builds,
        step && req.cmd == ppfb_pkg::CMD_CLAIM && status == ppfb_pkg::ST_OK,
        building_reg && !request_reg, "claim did not start a build")
    // A launched transfer is in flight afterwards.
    `PPFB_ASSERT_NEXT(a_launch_busy, step && started, inflight_reg,
        "launched transfer not marked in flight")

endmodule

[hdl/ping_pong_frame_buffer_control.sv]
// ----------------------------------------------------------------------------
// Ping-pong frame buffer control
// Request/response controller for two frame buffers shared by a producer
// and a periodic sender.
// ----------------------------------------------------------------------------
// Usage:
// Events (start, period tick, claim build, build done, transfer complete,
// transfer error) arrive as requests on the evt channel; each request gives
// exactly one response on the res channel with a status, the active and
// build buffer indices and the controller flags after that event.
// A request is registered on entry and its response is registered on exit.
// One request is taken every cycle unless the receiver stalls; the state flops
// update in one pass of short logic between the entry and exit registers.
// When the receiver stalls, the response is held and the entry register
// holds one more request; after that evt.ready falls until res.ready rises.
// Reset clears both registers and returns the controller to idle: buffer A
// active and the build target, buffer B marked as the ready slot, all flags
// clear.
// ----------------------------------------------------------------------------
module ping_pong_frame_buffer_control
(
    input logic       clk,
    input logic       rst_n,
    ppfb_evt_if.sink  evt,
    ppfb_res_if.source res
);

    logic            in_vld_reg;
    ppfb_pkg::req_t  in_req_reg;
    logic            out_vld_reg;
    ppfb_pkg::rsp_t  out_rsp_reg;
    ppfb_pkg::rsp_t  core_rsp;
    logic            advance;
    logic            step;

    // Stage control: the exit register frees up or is empty.
    assign advance   = !out_vld_reg || res.ready;
    assign step      = in_vld_reg && advance;
    assign evt.ready = !in_vld_reg || advance;

    // Entry register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (evt.ready)
        begin
            in_vld_reg <= evt.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt.ready && evt.valid)
        begin
            in_req_reg.cmd          <= evt.cmd;
            in_req_reg.start_result <= evt.start_result;
            in_req_reg.build_ok     <= evt.build_ok;
            in_req_reg.send_ok      <= evt.send_ok;
        end
    end

    ppfb_state_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .req   (in_req_reg),
        .rsp   (core_rsp)
    );

    // Exit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_rsp_reg <= core_rsp;
        end
    end

    assign res.valid           = out_vld_reg;
    assign res.status          = out_rsp_reg.status;
    assign res.active_buffer   = out_rsp_reg.active_buffer;
    assign res.build_buffer    = out_rsp_reg.build_buffer;
    assign res.send_started    = out_rsp_reg.send_started;
    assign res.not_ready       = out_rsp_reg.not_ready;
    assign res.busy_flag       = out_rsp_reg.busy_flag;
    assign res.ready_pending   = out_rsp_reg.ready_pending;
    assign res.build_requested = out_rsp_reg.build_requested;
    assign res.building        = out_rsp_reg.building;
    assign res.running         = out_rsp_reg.running;

endmodule
